[src/circular_queue_with_search_macros.svh]
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define CQS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cqs assertion failed");

// next-cycle implication, disabled during reset
`define CQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cqs assertion failed");

`endif

[src/cqs_pkg.sv]
`timescale 1ns / 1ps
package cqs_pkg;

    localparam int CMD_W       = 2;
    localparam int DATA_W      = 32;
    localparam int STAT_W      = 3;
    localparam int SLOT_W      = 4;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int DEPTH_DEF   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_PUSHED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ELEM    = 3'd3,
        ST_MATCH   = 3'd4,
        ST_NOMATCH = 3'd5
    } t_status;

endpackage

[src/cqs_cmd_if.sv]
`timescale 1ns / 1ps
interface cqs_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [cqs_pkg::CMD_W-1:0]    cmd;
    logic signed [cqs_pkg::DATA_W-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

[src/cqs_res_if.sv]
`timescale 1ns / 1ps
interface cqs_res_if;
    logic                                valid;
    logic                                ready;
    logic        [cqs_pkg::STAT_W-1:0]   status;
    logic signed [cqs_pkg::DATA_W-1:0]   data;
    logic        [cqs_pkg::SLOT_W-1:0]   slot;
    logic                                last;

    modport source (output valid, output status, output data, output slot, output last,
                    input ready);
    modport sink   (input valid, input status, input data, input slot, input last,
                    output ready);
endinterface

[src/cqs_ram.sv]
`timescale 1ns / 1ps
module cqs_ram #(
    parameter int WIDTH = cqs_pkg::DATA_W,
    parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[src/circular_queue_with_search.sv]
`timescale 1ns / 1ps
// Channel   Dir  Modport  Payload
// i_cmd     in   sink     cmd, value
// o_res     out  source   status, data, slot, last
//
// Push: result valid in the cycle after accept. Pop: registered RAM read, then the
// output register. Search: slots 0 to DEPTH-1, up to MAX_RESULTS hits, then S_FIN;
// dump: entries from head, up to MAX_RESULTS. The single RAM read port sets the walk
// rate, S_RD then S_CHK per slot. One command at a time; i_cmd.ready drops until its
// last word is taken. Reset clears head, tail and count; the store holds garbage
// until written. A stalled o_res holds the walk while a word waits; no word is dropped.
module circular_queue_with_search #(
    parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cqs_cmd_if.sink  i_cmd,
    cqs_res_if.source o_res
);
    import cqs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;
    localparam int CMP_W = (CNT_W > RES_CNT_W) ? CNT_W : RES_CNT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_RD   = 5'b00100,
        S_CHK  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]     r_occ, n_occ;
    logic [PTR_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_step, n_step;
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_pend, n_pend;
    logic [PTR_W-1:0]     r_pend_slot, n_pend_slot;
    logic                 r_srch, n_srch;
    logic [DATA_W-1:0]    r_val, n_val;
    logic                 r_out_valid, n_out_valid;
    logic [STAT_W-1:0]    r_out_status, n_out_status;
    logic [DATA_W-1:0]    r_out_data, n_out_data;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic                 r_out_last, n_out_last;

    logic                 w_out_free;
    logic                 w_accept;
    logic                 w_wr_en;
    logic                 w_rd_en;
    logic [PTR_W-1:0]     w_rd_addr;
    logic [DATA_W-1:0]    w_rd_data;
    logic [PTR_W:0]       w_off;
    logic                 w_occupied;
    logic                 w_hit;
    logic                 w_last_slot;
    logic [CMP_W-1:0]     w_step_next;
    logic                 w_dump_last;
    logic [RES_CNT_W-1:0] w_cnt_next;

    function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot(logic [PTR_W-1:0] p);
        logic [EXT_W-1:0] e;
        e = EXT_W'(p);
        return e[SLOT_W-1:0];
    endfunction

    cqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // offset of the walked slot from head, modulo DEPTH
    always_comb begin
        if (r_idx >= r_head) begin
            w_off = {1'b0, r_idx} - {1'b0, r_head};
        end else begin
            w_off = {1'b0, r_idx} + (PTR_W + 1)'(DEPTH) - {1'b0, r_head};
        end
    end

    assign w_occupied  = w_off < (PTR_W + 1)'(r_occ);
    assign w_hit       = w_occupied && (w_rd_data == r_val);
    assign w_last_slot = r_idx == PTR_W'(DEPTH - 1);
    assign w_step_next = CMP_W'(r_step) + 1'b1;
    assign w_dump_last = (w_step_next == CMP_W'(r_occ)) ||
                         (w_step_next == CMP_W'(MAX_RESULTS));
    assign w_cnt_next  = r_cnt + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_step       = r_step;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_pend_slot  = r_pend_slot;
        n_srch       = r_srch;
        n_val        = r_val;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_data = '0;
                    n_out_slot = '0;
                    n_out_last = 1'b1;
                    unique case (t_cmd'(i_cmd.cmd))
                        CMD_PUSH: begin
                            n_out_valid = 1'b1;
                            if (r_occ == CNT_W'(DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_wr_en      = 1'b1;
                                n_tail       = next_slot(r_tail);
                                n_occ        = r_occ + 1'b1;
                                n_out_status = ST_PUSHED;
                            end
                        end
                        CMD_POP: begin
                            if (r_occ == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                n_head    = next_slot(r_head);
                                n_occ     = r_occ - 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        CMD_SEARCH: begin
                            n_srch  = 1'b1;
                            n_val   = i_cmd.value;
                            n_idx   = '0;
                            n_cnt   = '0;
                            n_pend  = 1'b0;
                            n_state = S_RD;
                        end
                        CMD_DUMP: begin
                            if (r_occ == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_srch  = 1'b0;
                                n_idx   = r_head;
                                n_step  = '0;
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_POP: begin
                // RAM output holds until the word is taken
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ELEM;
                    n_out_data   = w_rd_data;
                    n_out_slot   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_srch) begin
                    // hold one match back so the final one can carry last
                    if (!(w_hit && r_pend && !w_out_free)) begin
                        if (w_hit) begin
                            if (r_pend) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_MATCH;
                                n_out_data   = '0;
                                n_out_slot   = to_slot(r_pend_slot);
                                n_out_last   = 1'b0;
                            end
                            n_pend      = 1'b1;
                            n_pend_slot = r_idx;
                            n_cnt       = w_cnt_next;
                        end
                        if (w_last_slot ||
                            (w_hit && w_cnt_next == RES_CNT_W'(MAX_RESULTS))) begin
                            n_state = S_FIN;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_RD;
                        end
                    end
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ELEM;
                    n_out_data   = w_rd_data;
                    n_out_slot   = to_slot(r_idx);
                    n_out_last   = w_dump_last;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = next_slot(r_idx);
                        n_step  = r_step + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = '0;
                    n_out_last   = 1'b1;
                    n_out_status = r_pend ? ST_MATCH : ST_NOMATCH;
                    n_out_slot   = r_pend ? to_slot(r_pend_slot) : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_srch      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_srch      <= n_srch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_step       <= n_step;
        r_cnt        <= n_cnt;
        r_pend_slot  <= n_pend_slot;
        r_val        <= n_val;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_slot   <= n_out_slot;
        r_out_last   <= n_out_last;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.data   = r_out_data;
    assign o_res.slot   = r_out_slot;
    assign o_res.last   = r_out_last;
endmodule

[src/cqs_checker.sv]
`timescale 1ns / 1ps
`include "circular_queue_with_search_macros.svh"
module cqs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [cqs_pkg::CMD_W-1:0]   i_in_cmd,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [cqs_pkg::STAT_W-1:0]  i_out_status,
    input logic                        i_out_last
);
    import cqs_pkg::*;

    logic              r_busy;
    logic [CMD_W-1:0]  r_cmd;
    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_single;
    logic              w_single_ok;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_out_acc   = i_out_valid && i_out_ready;
    assign w_single    = (r_cmd == CMD_PUSH) || (r_cmd == CMD_POP);
    assign w_single_ok = i_out_last &&
                         (i_out_status == ST_PUSHED || i_out_status == ST_FULL ||
                          i_out_status == ST_ELEM || i_out_status == ST_EMPTY);

    // a command is open from its accept until its last word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_acc) begin
            r_busy <= 1'b1;
        end else if (w_out_acc && i_out_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= i_in_cmd;
        end
    end

    `CQS_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, w_in_acc, !r_busy || (w_out_acc && i_out_last))
    `CQS_ASSERT_NOW(a_no_orphan_word, i_clk, i_rst_n, i_out_valid, r_busy)
    `CQS_ASSERT_NOW(a_single_result, i_clk, i_rst_n, i_out_valid && r_busy && w_single, w_single_ok)
    `CQS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_in_cmd     (i_cmd.cmd),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_status (o_res.status),
    .i_out_last   (o_res.last)
);

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import cqs_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int HOLDOFF_LEN  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_TIME  = 80;

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic [SLOT_W-1:0]        slot;
        logic                     last;
    } queue_reply;

    class queue_tracker;
        logic signed [DATA_W-1:0] words [QDEPTH];
        int unsigned              head;
        int unsigned              tail;
        int unsigned              count;
        queue_reply               pending [$];
        int                       errors;

        function new();
            head   = 0;
            tail   = 0;
            count  = 0;
            errors = 0;
        endfunction

        // work out every reply that one accepted command produces
        function void note_command(t_cmd c, logic signed [DATA_W-1:0] v);
            queue_reply  r;
            queue_reply  batch [$];
            int unsigned s;
            int unsigned idx;
            r.status = ST_PUSHED;
            r.data   = '0;
            r.slot   = '0;
            r.last   = 1'b0;
            case (c)
                CMD_PUSH: begin
                    if (count >= QDEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        words[tail] = v;
                        tail        = (tail + 1) % QDEPTH;
                        count++;
                        r.status    = ST_PUSHED;
                    end
                    batch.push_back(r);
                end
                CMD_POP: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.status = ST_ELEM;
                        r.data   = words[head];
                        head     = (head + 1) % QDEPTH;
                        count--;
                    end
                    batch.push_back(r);
                end
                CMD_SEARCH: begin
                    // scan physical slots in ascending order, occupied ones only
                    for (s = 0; s < QDEPTH && batch.size() < MAX_RESULTS; s++) begin
                        if (((s + QDEPTH - head) % QDEPTH) < count && words[s] == v) begin
                            r.status = ST_MATCH;
                            r.slot   = SLOT_W'(s);
                            batch.push_back(r);
                        end
                    end
                    if (batch.size() == 0) begin
                        r.status = ST_NOMATCH;
                        r.slot   = '0;
                        batch.push_back(r);
                    end
                end
                default: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                        batch.push_back(r);
                    end else begin
                        idx = head;
                        for (s = 0; s < count && batch.size() < MAX_RESULTS; s++) begin
                            r.status = ST_ELEM;
                            r.data   = words[idx];
                            r.slot   = SLOT_W'(idx);
                            batch.push_back(r);
                            idx = (idx + 1) % QDEPTH;
                        end
                    end
                end
            endcase
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k]) pending.push_back(batch[k]);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] d,
                                   logic [SLOT_W-1:0] sl, logic lst);
            queue_reply exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result word: status %0d data %0d slot %0d last %0b",
                       st, d, sl, lst);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (st !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, st);
                errors++;
            end
            if (d !== exp_r.data) begin
                $error("data: expected %0d, got %0d", exp_r.data, d);
                errors++;
            end
            if (sl !== exp_r.slot) begin
                $error("slot: expected %0d, got %0d", exp_r.slot, sl);
                errors++;
            end
            if (lst !== exp_r.last) begin
                $error("last: expected %0b, got %0b", exp_r.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    int unsigned  src_idle_pct;
    int unsigned  sink_idle_pct;
    bit           holdoff_armed;
    int unsigned  holdoff_left;
    queue_tracker tracker;

    cqs_cmd_if cmd_if ();
    cqs_res_if res_if ();

    circular_queue_with_search #(
        .DEPTH (QDEPTH)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: stall at random, or hold off for a long stretch once armed
    always @(negedge clk) begin
        if (holdoff_armed && holdoff_left > 0) begin
            res_if.ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready)
            tracker.check_result(res_if.status, res_if.data, res_if.slot, res_if.last);
    end

    task automatic send_cmd(t_cmd c, logic signed [DATA_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.cmd   <= c;
        cmd_if.value <= v;
        do @(posedge clk); while (!cmd_if.ready);
        tracker.note_command(c, v);
    endtask

    // mix raw random words with repeats of stored ones so searches hit
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(7)) - 4;
            2: begin
                if (tracker.count == 0) return $urandom;
                return tracker.words[(tracker.head + $urandom_range(tracker.count - 1))
                                     % QDEPTH];
            end
            default: begin
                case ($urandom_range(3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic run_phase(int n_items);
        int unsigned r;
        int unsigned push_w;
        int unsigned pop_w;
        t_cmd        c;
        for (int i = 0; i < n_items; i++) begin
            // alternate fill and drain stretches to reach full and empty
            if ((i / 25) % 2 == 0) begin
                push_w = 55;
                pop_w  = 20;
            end else begin
                push_w = 20;
                pop_w  = 55;
            end
            r = $urandom_range(99);
            if (r < push_w)
                c = CMD_PUSH;
            else if (r < push_w + pop_w)
                c = CMD_POP;
            else if (r < push_w + pop_w + 15)
                c = CMD_SEARCH;
            else
                c = CMD_DUMP;
            send_cmd(c, (c == CMD_PUSH || c == CMD_SEARCH) ? pick_value() : $urandom);
        end
    endtask

    initial begin
        int unsigned wait_cycles;
        tracker       = new();
        rst_n         = 1'b0;
        src_idle_pct  = 14;
        sink_idle_pct = 51;
        holdoff_armed = 1'b0;
        holdoff_left  = HOLDOFF_LEN;
        cmd_if.valid  = 1'b0;
        cmd_if.cmd    = CMD_PUSH;
        cmd_if.value  = '0;
        res_if.ready  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty queue: pop, dump and search
        send_cmd(CMD_POP, 32'sd0);
        send_cmd(CMD_DUMP, 32'sd0);
        send_cmd(CMD_SEARCH, 32'sd0);
        send_cmd(CMD_PUSH, 32'sh7FFF_FFFF);
        send_cmd(CMD_PUSH, 32'sh8000_0000);
        send_cmd(CMD_PUSH, 32'sd0);
        send_cmd(CMD_PUSH, -32'sd1);
        send_cmd(CMD_SEARCH, 32'sh8000_0000);
        send_cmd(CMD_SEARCH, 32'sd12345);
        send_cmd(CMD_POP, 32'sd0);
        // fill until the tail wraps onto the head, with repeats for search
        for (int i = 0; i < 13; i++)
            send_cmd(CMD_PUSH, (i % 3 == 0) ? -32'sd1 : $signed($urandom));
        send_cmd(CMD_PUSH, 32'sd7);
        send_cmd(CMD_DUMP, 32'sd0);
        send_cmd(CMD_SEARCH, -32'sd1);

        run_phase(42);

        src_idle_pct  = 51;
        sink_idle_pct = 14;
        holdoff_armed = 1'b1;
        run_phase(42);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(42);

        @(negedge clk);
        cmd_if.valid <= 1'b0;
        wait_cycles = 0;
        while (tracker.pending.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_TIME) @(posedge clk);
        if (tracker.pending.size() != 0) begin
            $error("%0d expected result words never arrived", tracker.pending.size());
            tracker.errors++;
        end

        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
